// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a signal group does not move unless an enable was high in the previous cycle.
`define ASSERT_HOLD(label, en, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !$past(en) |-> $stable(sig)) \
    else $error(msg);

`endif

// ===== rtl/core/cce_pkg.sv =====
// Types, constants and helpers shared by the CRC engine modules.
package cce_pkg;

  localparam int unsigned CrcW    = 64;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_MODE  = 3'd0,
    CFG_POLY        = 3'd1,
    CFG_SEED        = 3'd2,
    CFG_REFLECT_IN  = 3'd3,
    CFG_REFLECT_OUT = 3'd4,
    CFG_FINAL_XOR   = 3'd5
  } cfg_reg_e;

  // Width mode codes; the spare code behaves as 64 bits
  localparam logic [1:0] WIDTH_16 = 2'd0;
  localparam logic [1:0] WIDTH_32 = 2'd1;
  localparam logic [1:0] WIDTH_64 = 2'd2;

  localparam logic [1:0]      RstWidthMode = WIDTH_32;
  localparam logic [CrcW-1:0] RstPoly      = 64'h0000_0000_EDB8_8320;
  localparam logic [CrcW-1:0] RstSeed      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CrcW-1:0] RstFinalXor  = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]      width_mode;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] seed;
    logic            reflect_in;
    logic            reflect_out;
    logic [CrcW-1:0] final_xor;
  } crc_cfg_t;

  function automatic logic [CrcW-1:0] width_mask(logic [1:0] mode);
    logic [CrcW-1:0] m;
    unique case (mode)
      WIDTH_16: m = 64'h0000_0000_0000_FFFF;
      WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/configurable_crc_engine.sv =====
// Configurable CRC engine top level: stream ports, pipeline registers and checks.
//
// Byte-serial CRC-16/32/64 with programmable polynomial, seed, shift
// direction, output reflection and final XOR. One byte is taken every
// cycle while a last byte has room in the result register. A last byte
// has its CRC valid on m_axis once it leaves the input register: the
// input register feeds the XOR network straight into the result register.
// A last byte waits in the input register only while an earlier result
// is held by m_axis_tready. The running CRC register closes a loop
// through the eight-step XOR network. The polynomial is supplied reversed
// when reflect_in is set. Configuration is written through cfg_* (always
// ready) and must only change while no message is in flight.
module configurable_crc_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request input: tdata = {data_byte}, tuser = {first}, tlast = last
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
  input  logic                        s_axis_tuser,   // [0] first
  input  logic                        s_axis_tlast,
  // result output
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cce_pkg::CrcW-1:0]    m_axis_tdata,   // [63:0] crc_value
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cce_pkg::CrcW-1:0]    cfg_data_i
);
  import cce_pkg::*;
  `include "assert_macros.svh"

  crc_cfg_t cfg;

  logic            in_valid_d, in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_first_q;
  logic            in_last_q;
  logic [CrcW-1:0] running_d, running_q;
  logic            out_valid_d, out_valid_q;
  logic [CrcW-1:0] out_data_q;

  logic            s_accept;
  logic            advance;
  logic            emit;
  logic [CrcW-1:0] crc_start;
  logic [CrcW-1:0] crc_next;
  logic [CrcW-1:0] crc_final;
  logic            over_16;

  assign cfg_ready_o = 1'b1;

  cce_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a non-last byte always moves on; a last byte needs room in the result register
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign emit          = advance && in_last_q;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign crc_start = in_first_q ? cfg.seed : running_q;

  cce_byte_update u_update (
    .cfg_i  (cfg),
    .crc_i  (crc_start),
    .byte_i (in_byte_q),
    .crc_o  (crc_next)
  );

  cce_finalize u_final (
    .cfg_i   (cfg),
    .crc_i   (crc_next),
    .value_o (crc_final)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  assign running_d = advance ? crc_next : running_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      running_q   <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
    if (emit) begin
      out_data_q <= crc_final;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign over_16 = (cfg.width_mode == WIDTH_16) && (|out_data_q[63:16]);

  // a fresh result only follows a last byte leaving the input register
  `ASSERT_CLKD(a_result_from_last, $rose(out_valid_q) |-> $past(emit), "result without last")
  // the running CRC only moves when a byte is processed
  `ASSERT_HOLD(a_crc_hold, advance, running_q, "running CRC changed without a byte")
  // result bits above a 16-bit width stay clear
  `ASSERT_CLKD(a_mask_16, out_valid_q |-> !over_16, "16-bit result has upper bits set")

endmodule

// ===== rtl/core/cce_cfg_regs.sv =====
// Configuration register file of the CRC engine.
module cce_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [cce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cce_pkg::CrcW-1:0]    cfg_data_i,
  output cce_pkg::crc_cfg_t           cfg_o
);
  import cce_pkg::*;

  crc_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH_MODE:  cfg_d.width_mode  = cfg_data_i[1:0];
        CFG_POLY:        cfg_d.poly        = cfg_data_i;
        CFG_SEED:        cfg_d.seed        = cfg_data_i;
        CFG_REFLECT_IN:  cfg_d.reflect_in  = cfg_data_i[0];
        CFG_REFLECT_OUT: cfg_d.reflect_out = cfg_data_i[0];
        CFG_FINAL_XOR:   cfg_d.final_xor   = cfg_data_i;
        default:         cfg_d = cfg_q;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_mode  <= RstWidthMode;
      cfg_q.poly        <= RstPoly;
      cfg_q.seed        <= RstSeed;
      cfg_q.reflect_in  <= 1'b1;
      cfg_q.reflect_out <= 1'b1;
      cfg_q.final_xor   <= RstFinalXor;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/cce_byte_update.sv =====
// Eight-bit unrolled CRC update, shifting left or right by configuration.
module cce_byte_update (
  input  cce_pkg::crc_cfg_t        cfg_i,
  input  logic [cce_pkg::CrcW-1:0] crc_i,
  input  logic [7:0]               byte_i,
  output logic [cce_pkg::CrcW-1:0] crc_o
);
  import cce_pkg::*;

  logic [CrcW-1:0] mask;
  logic [CrcW-1:0] poly_m;
  logic [CrcW-1:0] c;
  logic            top;

  assign mask   = width_mask(cfg_i.width_mode);
  assign poly_m = cfg_i.poly & mask;

  always_comb begin
    c   = crc_i & mask;
    top = 1'b0;
    if (cfg_i.reflect_in) begin
      c[7:0] = c[7:0] ^ byte_i;
      for (int i = 0; i < 8; i++) begin
        c = (c >> 1) ^ (c[0] ? poly_m : '0);
      end
    end else begin
      // byte enters at the top of the active width
      unique case (cfg_i.width_mode)
        WIDTH_16: c[15:8]  = c[15:8]  ^ byte_i;
        WIDTH_32: c[31:24] = c[31:24] ^ byte_i;
        default:  c[63:56] = c[63:56] ^ byte_i;
      endcase
      for (int i = 0; i < 8; i++) begin
        unique case (cfg_i.width_mode)
          WIDTH_16: top = c[15];
          WIDTH_32: top = c[31];
          default:  top = c[63];
        endcase
        c = ((c << 1) ^ (top ? poly_m : '0)) & mask;
      end
    end
    crc_o = c & mask;
  end

endmodule

// ===== rtl/core/cce_finalize.sv =====
// Output stage: optional bit reversal over the width, final XOR and mask.
module cce_finalize (
  input  cce_pkg::crc_cfg_t        cfg_i,
  input  logic [cce_pkg::CrcW-1:0] crc_i,
  output logic [cce_pkg::CrcW-1:0] value_o
);
  import cce_pkg::*;

  logic [CrcW-1:0] rev;
  logic [CrcW-1:0] mirrored;
  logic [CrcW-1:0] sel;

  always_comb begin
    for (int i = 0; i < CrcW; i++) begin
      rev[i] = crc_i[CrcW-1-i];
    end
  end

  // upper bits of crc_i are zero, so the reversed word just needs shifting down
  always_comb begin
    unique case (cfg_i.width_mode)
      WIDTH_16: mirrored = {48'b0, rev[63:48]};
      WIDTH_32: mirrored = {32'b0, rev[63:32]};
      default:  mirrored = rev;
    endcase
  end

  assign sel     = (cfg_i.reflect_out != cfg_i.reflect_in) ? mirrored : crc_i;
  assign value_o = (sel ^ cfg_i.final_xor) & width_mask(cfg_i.width_mode);

endmodule
